// ===== sv/phg_pkg.sv =====
// Types, constants and the arctangent table of the pursuit heading guidance pipeline.
package phg_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_MAX_SPEED     = 2'd0;
    localparam logic [1:0] REG_POINT_RADIUS  = 2'd1;
    localparam logic [1:0] REG_TARGET_RADIUS = 2'd2;

    // Widths of the working values
    localparam int SQW = 50;   // squared distance and root working width
    localparam int CW  = 38;   // rotator x and z width
    localparam int AW  = 26;   // angle accumulator width, degrees with 16 fractional bits
    localparam int SQ_N = 25;  // result bits of the square roots
    localparam int DV_N = 16;  // quotient bits of the intercept time

    localparam logic signed [AW-1:0] ANG_90      = AW'(90 * 65536);
    localparam logic signed [AW-1:0] HEAD_LIMIT  = AW'(23040);
    localparam logic signed [AW-1:0] ROUND_HALF  = AW'(256);

    // Front stage: differences and selected radius
    typedef struct packed {
        logic               op;
        logic signed [24:0] dx;
        logic signed [24:0] dz;
        logic signed [16:0] rvx;
        logic signed [16:0] rvz;
        logic signed [15:0] gvx;
        logic signed [15:0] gvz;
        logic [15:0]        radius;
    } front_t;

    // Square stage
    typedef struct packed {
        logic               op;
        logic signed [24:0] dx;
        logic signed [24:0] dz;
        logic signed [15:0] gvx;
        logic signed [15:0] gvz;
        logic [49:0]        dx2;
        logic [49:0]        dz2;
        logic [33:0]        vx2;
        logic [33:0]        vz2;
        logic [31:0]        rad2;
    } square_t;

    // Square root stages, both roots side by side
    typedef struct packed {
        logic               op;
        logic signed [24:0] dx;
        logic signed [24:0] dz;
        logic signed [15:0] gvx;
        logic signed [15:0] gvz;
        logic               arrived;
        logic [SQW-1:0]     vd;
        logic [SQW-1:0]     rd;
        logic [SQW-1:0]     vv;
        logic [SQW-1:0]     rv;
    } root_t;

    // Divider stages
    typedef struct packed {
        logic               op;
        logic signed [24:0] dx;
        logic signed [24:0] dz;
        logic signed [15:0] gvx;
        logic signed [15:0] gvz;
        logic               arrived;
        logic [16:0]        lv;
        logic [16:0]        rem;
        logic [15:0]        quo;
        logic [15:0]        nb;
        logic               sat;
        logic               lvz;
    } div_t;

    // Prediction product stage
    typedef struct packed {
        logic signed [24:0] dx;
        logic signed [24:0] dz;
        logic               arrived;
        logic signed [32:0] px;
        logic signed [32:0] pz;
    } pred_t;

    // Aim vector stage
    typedef struct packed {
        logic signed [25:0] ax;
        logic signed [25:0] az;
        logic               arrived;
    } aim_t;

    // Rotator stages
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] z;
        logic signed [AW-1:0] ang;
        logic                 zero;
        logic                 arrived;
    } rot_t;

    // atan(2^-i) in degrees, 16 fractional bits
    function automatic logic signed [AW-1:0] atan_q16(input logic [4:0] idx);
        logic signed [AW-1:0] v;
        case (idx)
            5'd0:  v = AW'(2949120);
            5'd1:  v = AW'(1740967);
            5'd2:  v = AW'(919879);
            5'd3:  v = AW'(466945);
            5'd4:  v = AW'(234379);
            5'd5:  v = AW'(117304);
            5'd6:  v = AW'(58666);
            5'd7:  v = AW'(29335);
            5'd8:  v = AW'(14668);
            5'd9:  v = AW'(7334);
            5'd10: v = AW'(3667);
            5'd11: v = AW'(1833);
            5'd12: v = AW'(917);
            5'd13: v = AW'(458);
            5'd14: v = AW'(229);
            5'd15: v = AW'(115);
            5'd16: v = AW'(57);
            5'd17: v = AW'(29);
            5'd18: v = AW'(14);
            5'd19: v = AW'(7);
            5'd20: v = AW'(4);
            5'd21: v = AW'(2);
            5'd22: v = AW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/pursuit_heading_guidance_top.sv =====
// Pursuit heading guidance: pipelined intercept time, aim vector and CORDIC heading.
//
// Input channel (in_valid / in_ready) takes one word per cycle while in_ready is high:
// operation, own and goal position and velocity. Output channel (out_valid / out_ready)
// returns one word for each input word, in order: heading_deg, speed_cmd and arrived.
// Configuration channel (cfg_valid / cfg_ready, always ready) writes max_speed (0),
// point_arrive_radius (1) and target_arrive_radius (2); other indexes are dropped.
// Write configuration only while no word is in flight.
// The path from input accept to output valid runs through 3 front stages, 25 root stages
// (one root bit each), 16 divider stages (one quotient bit each), 3 prediction, aim and
// fold stages, one rotator stage per CORDIC step and the output register. Throughput is
// one word per cycle while the receiver does not stall.
// The whole pipeline advances on one enable: it moves while the output register is
// empty or taken. When the receiver stalls, every stage holds and in_ready falls,
// so nothing is lost or repeated.
// Reset empties the pipeline and loads max_speed 0, point radius 160, target radius 480.
module pursuit_heading_guidance_top #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               operation,
    input  logic signed [23:0] own_x,
    input  logic signed [23:0] own_z,
    input  logic signed [15:0] own_vx,
    input  logic signed [15:0] own_vz,
    input  logic signed [23:0] goal_x,
    input  logic signed [23:0] goal_z,
    input  logic signed [15:0] goal_vx,
    input  logic signed [15:0] goal_vz,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] heading_deg,
    output logic [15:0]        speed_cmd,
    output logic               arrived,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    localparam int NS = CORDIC_STEPS;
    localparam int SQN = phg_pkg::SQ_N;
    localparam int DVN = phg_pkg::DV_N;
    localparam int SQW = phg_pkg::SQW;
    localparam int CW = phg_pkg::CW;
    localparam int AW = phg_pkg::AW;

    logic        adv;
    logic [15:0] max_speed_reg;
    logic [15:0] point_radius_reg;
    logic [15:0] target_radius_reg;

    phg_pkg::front_t  fr_reg,  fr_next;
    phg_pkg::square_t sqr_reg, sqr_next;
    phg_pkg::root_t   c_reg,   c_next;
    phg_pkg::root_t   rt_reg   [SQN];
    phg_pkg::root_t   rt_next  [SQN];
    phg_pkg::div_t    dv_init;
    phg_pkg::div_t    dv_reg   [DVN];
    phg_pkg::div_t    dv_next  [DVN];
    phg_pkg::pred_t   pr_reg,  pr_next;
    phg_pkg::aim_t    am_reg,  am_next;
    phg_pkg::rot_t    p_reg,   p_next;
    phg_pkg::rot_t    ro_reg   [NS];
    phg_pkg::rot_t    ro_next  [NS];

    logic fr_vld_reg, sqr_vld_reg, c_vld_reg, pr_vld_reg, am_vld_reg, p_vld_reg;
    logic [SQN-1:0] rt_vld_reg;
    logic [DVN-1:0] dv_vld_reg;
    logic [NS-1:0]  ro_vld_reg;
    logic               out_valid_reg;
    logic signed [15:0] heading_reg, heading_next;
    logic [15:0]        speed_reg, speed_next;
    logic               arrived_reg;

    // Advance the whole pipeline while the output register can move
    assign adv       = !out_valid_reg || out_ready;
    assign in_ready  = adv;
    assign cfg_ready = 1'b1;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_speed_reg     <= '0;
            point_radius_reg  <= 16'd160;
            target_radius_reg <= 16'd480;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                phg_pkg::REG_MAX_SPEED:     max_speed_reg     <= cfg_data;
                phg_pkg::REG_POINT_RADIUS:  point_radius_reg  <= cfg_data;
                phg_pkg::REG_TARGET_RADIUS: target_radius_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Front: differences and radius choice
    always_comb
    begin
        fr_next.op     = operation;
        fr_next.dx     = 25'(goal_x) - 25'(own_x);
        fr_next.dz     = 25'(goal_z) - 25'(own_z);
        fr_next.rvx    = 17'(goal_vx) - 17'(own_vx);
        fr_next.rvz    = 17'(goal_vz) - 17'(own_vz);
        fr_next.gvx    = goal_vx;
        fr_next.gvz    = goal_vz;
        fr_next.radius = operation ? target_radius_reg : point_radius_reg;
    end

    // Squares of magnitudes
    always_comb
    begin
        logic [24:0] adx, adz;
        logic [16:0] avx, avz;
        adx = fr_reg.dx[24] ? 25'(-fr_reg.dx) : 25'(fr_reg.dx);
        adz = fr_reg.dz[24] ? 25'(-fr_reg.dz) : 25'(fr_reg.dz);
        avx = fr_reg.rvx[16] ? 17'(-fr_reg.rvx) : 17'(fr_reg.rvx);
        avz = fr_reg.rvz[16] ? 17'(-fr_reg.rvz) : 17'(fr_reg.rvz);
        sqr_next.op   = fr_reg.op;
        sqr_next.dx   = fr_reg.dx;
        sqr_next.dz   = fr_reg.dz;
        sqr_next.gvx  = fr_reg.gvx;
        sqr_next.gvz  = fr_reg.gvz;
        sqr_next.dx2  = 50'(adx) * 50'(adx);
        sqr_next.dz2  = 50'(adz) * 50'(adz);
        sqr_next.vx2  = 34'(avx) * 34'(avx);
        sqr_next.vz2  = 34'(avz) * 34'(avz);
        sqr_next.rad2 = 32'(fr_reg.radius) * 32'(fr_reg.radius);
    end

    // Sums of squares and arrival test
    always_comb
    begin
        logic [SQW-1:0] d2;
        d2 = sqr_reg.dx2 + sqr_reg.dz2;
        c_next.op      = sqr_reg.op;
        c_next.dx      = sqr_reg.dx;
        c_next.dz      = sqr_reg.dz;
        c_next.gvx     = sqr_reg.gvx;
        c_next.gvz     = sqr_reg.gvz;
        c_next.arrived = d2 < SQW'(sqr_reg.rad2);
        c_next.vd      = d2;
        c_next.rd      = '0;
        c_next.vv      = SQW'(sqr_reg.vx2) + SQW'(sqr_reg.vz2);
        c_next.rv      = '0;
    end

    // Square roots: one result bit per stage
    for (genvar k = 0; k < SQN; k++)
    begin : g_root
        localparam logic [SQW-1:0] BITV = SQW'(1) << (SQW - 2 - 2 * k);
        phg_pkg::root_t prev;
        if (k == 0)
        begin : g_first
            assign prev = c_reg;
        end
        else
        begin : g_rest
            assign prev = rt_reg[k-1];
        end
        always_comb
        begin
            logic [SQW-1:0] cd, cv;
            cd = prev.rd + BITV;
            cv = prev.rv + BITV;
            rt_next[k] = prev;
            if (prev.vd >= cd)
            begin
                rt_next[k].vd = prev.vd - cd;
                rt_next[k].rd = (prev.rd >> 1) + BITV;
            end
            else
            begin
                rt_next[k].rd = prev.rd >> 1;
            end
            if (prev.vv >= cv)
            begin
                rt_next[k].vv = prev.vv - cv;
                rt_next[k].rv = (prev.rv >> 1) + BITV;
            end
            else
            begin
                rt_next[k].rv = prev.rv >> 1;
            end
        end
    end

    // Divider set-up: saturation and zero speed checks
    always_comb
    begin
        logic [24:0] len;
        logic [16:0] lv;
        len = rt_reg[SQN-1].rd[24:0];
        lv  = rt_reg[SQN-1].rv[16:0];
        dv_init.op      = rt_reg[SQN-1].op;
        dv_init.dx      = rt_reg[SQN-1].dx;
        dv_init.dz      = rt_reg[SQN-1].dz;
        dv_init.gvx     = rt_reg[SQN-1].gvx;
        dv_init.gvz     = rt_reg[SQN-1].gvz;
        dv_init.arrived = rt_reg[SQN-1].arrived;
        dv_init.lv      = lv;
        dv_init.rem     = len[24:8];
        dv_init.quo     = '0;
        dv_init.nb      = {len[7:0], 8'h00};
        dv_init.sat     = len >= {lv, 8'h00};
        dv_init.lvz     = lv == '0;
    end

    // Intercept time: one quotient bit per stage
    for (genvar k = 0; k < DVN; k++)
    begin : g_div
        phg_pkg::div_t prev;
        if (k == 0)
        begin : g_first
            assign prev = dv_init;
        end
        else
        begin : g_rest
            assign prev = dv_reg[k-1];
        end
        always_comb
        begin
            logic [17:0] rem2;
            logic        ge;
            rem2 = {prev.rem, prev.nb[15]};
            ge   = rem2 >= {1'b0, prev.lv};
            dv_next[k]     = prev;
            dv_next[k].rem = ge ? 17'(rem2 - {1'b0, prev.lv}) : rem2[16:0];
            dv_next[k].quo = {prev.quo[14:0], ge};
            dv_next[k].nb  = {prev.nb[14:0], 1'b0};
        end
    end

    // Predicted offsets of the target
    always_comb
    begin
        logic [15:0]        t;
        logic signed [16:0] ts;
        if (!dv_reg[DVN-1].op || dv_reg[DVN-1].lvz)
            t = '0;
        else if (dv_reg[DVN-1].sat)
            t = 16'hFFFF;
        else
            t = dv_reg[DVN-1].quo;
        ts = {1'b0, t};
        pr_next.dx      = dv_reg[DVN-1].dx;
        pr_next.dz      = dv_reg[DVN-1].dz;
        pr_next.arrived = dv_reg[DVN-1].arrived;
        pr_next.px      = 33'(dv_reg[DVN-1].gvx) * 33'(ts);
        pr_next.pz      = 33'(dv_reg[DVN-1].gvz) * 33'(ts);
    end

    // Aim vector relative to own position
    always_comb
    begin
        am_next.ax      = 26'(pr_reg.dx) + 26'($signed(pr_reg.px[32:8]));
        am_next.az      = 26'(pr_reg.dz) + 26'($signed(pr_reg.pz[32:8]));
        am_next.arrived = pr_reg.arrived;
    end

    // Scale and fold the left half plane into the right
    always_comb
    begin
        logic signed [CW-1:0] xw, zw;
        xw = {{(CW-34){am_reg.ax[25]}}, am_reg.ax, 8'h00};
        zw = {{(CW-34){am_reg.az[25]}}, am_reg.az, 8'h00};
        p_next.zero    = (am_reg.ax == '0) && (am_reg.az == '0);
        p_next.arrived = am_reg.arrived;
        p_next.x       = xw;
        p_next.z       = zw;
        p_next.ang     = '0;
        if (xw < 0)
        begin
            if (zw >= 0)
            begin
                p_next.x   = zw;
                p_next.z   = -xw;
                p_next.ang = phg_pkg::ANG_90;
            end
            else
            begin
                p_next.x   = -zw;
                p_next.z   = xw;
                p_next.ang = -phg_pkg::ANG_90;
            end
        end
    end

    // Vectoring rotator: one step per stage
    for (genvar i = 0; i < NS; i++)
    begin : g_rot
        phg_pkg::rot_t prev;
        if (i == 0)
        begin : g_first
            assign prev = p_reg;
        end
        else
        begin : g_rest
            assign prev = ro_reg[i-1];
        end
        always_comb
        begin
            logic signed [CW-1:0] xs, zs;
            logic signed [AW-1:0] da;
            xs = prev.x >>> i;
            zs = prev.z >>> i;
            da = phg_pkg::atan_q16(5'(i));
            ro_next[i] = prev;
            if (prev.z >= 0)
            begin
                ro_next[i].x   = prev.x + zs;
                ro_next[i].z   = prev.z - xs;
                ro_next[i].ang = prev.ang + da;
            end
            else
            begin
                ro_next[i].x   = prev.x - zs;
                ro_next[i].z   = prev.z + xs;
                ro_next[i].ang = prev.ang - da;
            end
        end
    end

    // Round, clamp and pick the speed
    always_comb
    begin
        logic signed [AW-1:0] r;
        r = (ro_reg[NS-1].ang + phg_pkg::ROUND_HALF) >>> 9;
        if (ro_reg[NS-1].zero)
            heading_next = '0;
        else if (r > phg_pkg::HEAD_LIMIT)
            heading_next = 16'(phg_pkg::HEAD_LIMIT);
        else if (r < -phg_pkg::HEAD_LIMIT)
            heading_next = 16'(-phg_pkg::HEAD_LIMIT);
        else
            heading_next = r[15:0];
        speed_next = ro_reg[NS-1].arrived ? '0 : max_speed_reg;
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fr_vld_reg    <= 1'b0;
            sqr_vld_reg   <= 1'b0;
            c_vld_reg     <= 1'b0;
            rt_vld_reg    <= '0;
            dv_vld_reg    <= '0;
            pr_vld_reg    <= 1'b0;
            am_vld_reg    <= 1'b0;
            p_vld_reg     <= 1'b0;
            ro_vld_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            fr_vld_reg    <= in_valid;
            sqr_vld_reg   <= fr_vld_reg;
            c_vld_reg     <= sqr_vld_reg;
            rt_vld_reg    <= {rt_vld_reg[SQN-2:0], c_vld_reg};
            dv_vld_reg    <= {dv_vld_reg[DVN-2:0], rt_vld_reg[SQN-1]};
            pr_vld_reg    <= dv_vld_reg[DVN-1];
            am_vld_reg    <= pr_vld_reg;
            p_vld_reg     <= am_vld_reg;
            ro_vld_reg    <= {ro_vld_reg[NS-2:0], p_vld_reg};
            out_valid_reg <= ro_vld_reg[NS-1];
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fr_reg  <= fr_next;
            sqr_reg <= sqr_next;
            c_reg   <= c_next;
            for (int k = 0; k < SQN; k++)
                rt_reg[k] <= rt_next[k];
            for (int k = 0; k < DVN; k++)
                dv_reg[k] <= dv_next[k];
            pr_reg  <= pr_next;
            am_reg  <= am_next;
            p_reg   <= p_next;
            for (int i = 0; i < NS; i++)
                ro_reg[i] <= ro_next[i];
            heading_reg <= heading_next;
            speed_reg   <= speed_next;
            arrived_reg <= ro_reg[NS-1].arrived;
        end
    end

    assign out_valid   = out_valid_reg;
    assign heading_deg = heading_reg;
    assign speed_cmd   = speed_reg;
    assign arrived     = arrived_reg;

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the pursuit heading guidance pipeline.
`timescale 1ns / 1ps

module testbench;

    localparam int         LATENCY    = 64;
    localparam logic [1:0] REG_SPARE  = 2'd3;
    localparam logic       OP_POINT   = 1'b0;
    localparam logic       OP_INTERCEPT = 1'b1;

    typedef struct {
        logic               op;
        logic signed [23:0] ox, oz, gx, gz;
        logic signed [15:0] ovx, ovz, gvx, gvz;
    } guide_word_t;

    typedef struct {
        logic signed [15:0] heading;
        logic [15:0]        speed;
        logic               arrived;
    } steer_word_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               operation = 1'b0;
    logic signed [23:0] own_x = '0, own_z = '0, goal_x = '0, goal_z = '0;
    logic signed [15:0] own_vx = '0, own_vz = '0, goal_vx = '0, goal_vz = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [15:0] heading_deg;
    logic [15:0]        speed_cmd;
    logic               arrived;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = '0;
    logic [15:0]        cfg_data = '0;

    // Shadow copies of the registers
    logic [15:0] speed_limit = 16'd0;
    logic [15:0] point_radius = 16'd160;
    logic [15:0] target_radius = 16'd480;

    steer_word_t steer_q[$];
    int          errors = 0;
    int          words_sent = 0;
    int          words_checked = 0;
    int          arrivals = 0;
    bit          steady = 1'b0;

    pursuit_heading_guidance_top u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .operation(operation),
        .own_x(own_x), .own_z(own_z), .own_vx(own_vx), .own_vz(own_vz),
        .goal_x(goal_x), .goal_z(goal_z), .goal_vx(goal_vx), .goal_vz(goal_vz),
        .out_valid(out_valid), .out_ready(out_ready),
        .heading_deg(heading_deg), .speed_cmd(speed_cmd), .arrived(arrived),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    function automatic longint unsigned int_root(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint heading_of(longint z, longint x);
        longint ang;
        longint t;
        longint xs;
        longint zs;
        ang = 0;
        if (x == 0 && z == 0)
            return 0;
        x = x * 256;
        z = z * 256;
        // Fold the left half-plane onto the right
        if (x < 0)
        begin
            if (z >= 0)
            begin
                t = x; x = z; z = -t; ang = 90 * 65536;
            end
            else
            begin
                t = x; x = -z; z = t; ang = -90 * 65536;
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            xs = x >>> i;
            zs = z >>> i;
            if (z >= 0)
            begin
                x = x + zs; z = z - xs;
                ang = ang + longint'(phg_pkg::atan_q16(5'(i)));
            end
            else
            begin
                x = x - zs; z = z + xs;
                ang = ang - longint'(phg_pkg::atan_q16(5'(i)));
            end
        end
        ang = (ang + 256) >>> 9;
        if (ang > 23040) ang = 23040;
        if (ang < -23040) ang = -23040;
        return ang;
    endfunction

    function automatic steer_word_t steer_for(guide_word_t w);
        steer_word_t     s;
        longint          dx, dz, ax, az, rvx, rvz;
        longint unsigned d2, lv, tt, rad;
        dx = longint'(w.gx) - longint'(w.ox);
        dz = longint'(w.gz) - longint'(w.oz);
        d2 = dx * dx + dz * dz;
        ax = dx;
        az = dz;
        if (w.op == OP_INTERCEPT)
        begin
            rvx = longint'(w.gvx) - longint'(w.ovx);
            rvz = longint'(w.gvz) - longint'(w.ovz);
            lv = int_root(rvx * rvx + rvz * rvz);
            tt = 0;
            if (lv != 0)
            begin
                tt = (int_root(d2) << 8) / lv;
                if (tt > 65535) tt = 65535;
            end
            ax = dx + ((longint'(w.gvx) * longint'(tt)) >>> 8);
            az = dz + ((longint'(w.gvz) * longint'(tt)) >>> 8);
        end
        rad = (w.op == OP_INTERCEPT) ? target_radius : point_radius;
        s.heading = 16'(heading_of(az, ax));
        s.arrived = d2 < rad * rad;
        s.speed   = s.arrived ? 16'd0 : speed_limit;
        return s;
    endfunction

    function automatic bit idle_now();
        return !steady && ($urandom_range(99) < 14);
    endfunction

    // Send one word, idling first at random
    task automatic send_word(guide_word_t w);
        while (idle_now())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= w.op;
        own_x <= w.ox;   own_z <= w.oz;   own_vx <= w.ovx;  own_vz <= w.ovz;
        goal_x <= w.gx;  goal_z <= w.gz;  goal_vx <= w.gvx; goal_vz <= w.gvz;
        do
            @(negedge clk);
        while (!in_ready);
        @(posedge clk);
        steer_q.push_back(steer_for(w));
        words_sent++;
    endtask

    // Drop the input valid and wait for every word to come out
    task automatic drain();
        in_valid <= 1'b0;
        while (steer_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 16) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(negedge clk);
        while (!cfg_ready);
        @(posedge clk);
        case (idx)
            phg_pkg::REG_MAX_SPEED:     speed_limit = data;
            phg_pkg::REG_POINT_RADIUS:  point_radius = data;
            phg_pkg::REG_TARGET_RADIUS: target_radius = data;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_regs(logic [15:0] spd, logic [15:0] pr, logic [15:0] tr);
        drain();
        write_reg(phg_pkg::REG_MAX_SPEED, spd);
        write_reg(phg_pkg::REG_POINT_RADIUS, pr);
        write_reg(phg_pkg::REG_TARGET_RADIUS, tr);
    endtask

    function automatic guide_word_t make_word(logic op, longint ox, longint oz,
                                              longint dx, longint dz, longint ovx,
                                              longint ovz, longint gvx, longint gvz);
        guide_word_t w;
        w.op = op;
        w.ox = 24'(ox);       w.oz = 24'(oz);
        w.gx = 24'(ox + dx);  w.gz = 24'(oz + dz);
        w.ovx = 16'(ovx);     w.ovz = 16'(ovz);
        w.gvx = 16'(gvx);     w.gvz = 16'(gvz);
        return w;
    endfunction

    // Random word: wide spread, near approach, or matched velocities
    function automatic guide_word_t random_word(logic op);
        guide_word_t w;
        int          kind;
        kind = $urandom_range(9);
        w.op  = op;
        w.ox  = 24'($urandom);  w.oz  = 24'($urandom);
        w.gx  = 24'($urandom);  w.gz  = 24'($urandom);
        w.ovx = 16'($urandom);  w.ovz = 16'($urandom);
        w.gvx = 16'($urandom);  w.gvz = 16'($urandom);
        if (kind < 4)
        begin
            w.ox = 24'($signed($urandom_range(2000000)) - 1000000);
            w.oz = 24'($signed($urandom_range(2000000)) - 1000000);
            w.gx = w.ox + 24'($signed($urandom_range(1200)) - 600);
            w.gz = w.oz + 24'($signed($urandom_range(1200)) - 600);
        end
        if (kind == 5)
        begin
            w.gvx = w.ovx;
            w.gvz = w.ovz;
        end
        if (kind == 6)
        begin
            w.gvx = w.ovx + 16'($urandom_range(2));
            w.gvz = w.ovz;
        end
        return w;
    endfunction

    // Check each word taken from the output
    always @(negedge clk)
    begin
        steer_word_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (steer_q.size() == 0)
            begin
                $display("%0t: unexpected word heading %0d speed %0d arrived %0d",
                         $time, heading_deg, speed_cmd, arrived);
                errors++;
            end
            else
            begin
                e = steer_q.pop_front();
                words_checked++;
                if (arrived) arrivals++;
                if (heading_deg !== e.heading)
                begin
                    $display("%0t: heading_deg expected %0d actual %0d",
                             $time, e.heading, heading_deg);
                    errors++;
                end
                if (speed_cmd !== e.speed)
                begin
                    $display("%0t: speed_cmd expected %0d actual %0d",
                             $time, e.speed, speed_cmd);
                    errors++;
                end
                if (arrived !== e.arrived)
                begin
                    $display("%0t: arrived expected %0d actual %0d",
                             $time, e.arrived, arrived);
                    errors++;
                end
            end
        end
    end

    // Stall the receiver at random
    always @(posedge clk)
        out_ready <= steady || ($urandom_range(99) >= 14);

    task automatic test_directed();
        set_regs(16'd1000, 16'd160, 16'd480);
        send_word(make_word(OP_POINT, 0, 0, 0, 0, 0, 0, 0, 0));
        send_word(make_word(OP_POINT, 100, 100, -500, 0, 0, 0, 0, 0));
        send_word(make_word(OP_POINT, 0, 0, 0, 900, 0, 0, 0, 0));
        send_word(make_word(OP_POINT, 0, 0, 0, -900, 0, 0, 0, 0));
        send_word(make_word(OP_POINT, 0, 0, 159, 0, 0, 0, 0, 0));
        send_word(make_word(OP_POINT, 0, 0, 160, 0, 0, 0, 0, 0));
        send_word(make_word(OP_POINT, -8388608, -8388608, 16777215, 16777215,
                            -32768, -32768, 32767, 32767));
        send_word(make_word(OP_POINT, 8388607, 8388607, -16777215, -16777215,
                            32767, 32767, -32768, -32768));
        send_word(make_word(OP_INTERCEPT, 0, 0, 3000, 2000, 50, 50, 50, 50));
        send_word(make_word(OP_INTERCEPT, -8388608, 8388607, 16777215, -16777215,
                            0, 0, 1, 0));
        send_word(make_word(OP_INTERCEPT, 8388607, -8388608, -16777215, 16777215,
                            32767, -32768, -32768, 32767));
        send_word(make_word(OP_INTERCEPT, 0, 0, 0, 0, 0, 0, 0, 0));
        send_word(make_word(OP_INTERCEPT, 0, 0, -4000, 0, 0, 0, 0, 0));
        send_word(make_word(OP_INTERCEPT, 0, 0, 479, 0, 10, 0, -10, 0));
        send_word(make_word(OP_INTERCEPT, 0, 0, 480, 0, 10, 0, -10, 0));
        send_word(make_word(OP_INTERCEPT, 0, 0, 10000, 0, 0, 0, -20, 0));
        send_word(make_word(OP_INTERCEPT, 0, 0, 5000, 5000, 32767, 32767, -32768, -32768));
        drain();
    endtask

    task automatic test_register_extremes();
        set_regs(16'hFFFF, 16'd0, 16'd0);
        write_reg(REG_SPARE, 16'hFFFF);
        for (int i = 0; i < 20; i++)
            send_word(random_word(1'($urandom)));
        set_regs(16'd0, 16'hFFFF, 16'hFFFF);
        write_reg(REG_SPARE, 16'h0000);
        for (int i = 0; i < 20; i++)
            send_word(random_word(1'($urandom)));
        drain();
    endtask

    task automatic test_random_point();
        set_regs(16'($urandom), 16'($urandom_range(600)), 16'($urandom_range(600)));
        for (int i = 0; i < 200; i++)
            send_word(random_word(OP_POINT));
    endtask

    task automatic test_random_intercept();
        set_regs(16'($urandom), 16'($urandom_range(600)), 16'($urandom_range(600)));
        for (int i = 0; i < 200; i++)
            send_word(random_word(OP_INTERCEPT));
    endtask

    task automatic test_back_to_back();
        set_regs(16'($urandom), 16'($urandom), 16'($urandom));
        steady = 1'b1;
        for (int i = 0; i < 120; i++)
            send_word(random_word(1'($urandom)));
        steady = 1'b0;
        drain();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_register_extremes();
        test_random_point();
        test_random_intercept();
        test_back_to_back();
        drain();
        $display("Checked %0d of %0d guidance words, %0d arrivals, both operations",
                 words_checked, words_sent, arrivals);
        $display("under random idling, full-rate bursts and extreme register values.");
        if (errors == 0 && steer_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Hold a hard stop well past the slowest correct run
    initial
    begin
        #20ms;
        $display("Timed out with %0d words outstanding", steer_q.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
